@@ design/qwfi_pkg.sv @@
// Shared types and constants for the queue with front insert.
package qwfi_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam int OP_W     = 2;
    localparam int ID_W     = 16;
    localparam int CAP_W    = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_TAIL = 2'd0,
        OP_PUSH_HEAD = 2'd1,
        OP_POP_HEAD  = 2'd2,
        OP_PEEK      = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_READ,
        CTRL_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
        logic load_out;
    } qwfi_cmd_t;

    typedef struct packed {
        logic out_free;
    } qwfi_status_t;

endpackage

@@ design/qwfi_ctrl.sv @@
// Controller state machine: accept, head read, result load.
module qwfi_ctrl
    import qwfi_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  qwfi_status_t dp_status,
    output qwfi_cmd_t    dp_cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTRL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CTRL_IDLE: begin
                if (s_valid) begin
                    state_next = CTRL_READ;
                end
            end
            CTRL_READ: begin
                state_next = CTRL_LOAD;
            end
            CTRL_LOAD: begin
                if (dp_status.out_free) begin
                    state_next = CTRL_IDLE;
                end
            end
            default: begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready         = 1'b0;
        dp_cmd.exec     = 1'b0;
        dp_cmd.load_out = 1'b0;
        case (state_reg)
            CTRL_IDLE: begin
                s_ready     = 1'b1;
                dp_cmd.exec = s_valid;
            end
            CTRL_LOAD: begin
                dp_cmd.load_out = dp_status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ design/qwfi_datapath.sv @@
// Datapath: ring store, head/tail pointers, held count and result register.
module qwfi_datapath
    import qwfi_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  qwfi_cmd_t           dp_cmd,
    output qwfi_status_t        dp_status,
    input  logic [OP_W-1:0]     s_op,
    input  logic [ID_W-1:0]     s_entry_id,
    input  logic [CAP_W-1:0]    s_entry_capacity,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_head_valid,
    output logic [ID_W-1:0]     m_head_id,
    output logic [CAP_W-1:0]    m_head_capacity,
    output logic [COUNT_W-1:0]  m_entry_count
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int REC_W = ID_W + CAP_W;

    logic [REC_W-1:0] store_mem [QUEUE_DEPTH];
    logic [REC_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    status_t          status_reg;
    status_t          status_next;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic                 out_head_valid_reg;
    logic [ID_W-1:0]      out_head_id_reg;
    logic [CAP_W-1:0]     out_head_capacity_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic             full;
    logic             empty;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] head_prev;
    logic [IDX_W-1:0] head_succ;
    logic [IDX_W-1:0] tail_succ;
    logic [CNT_W+COUNT_W-1:0] count_wide;
    op_t              op;

    assign op    = op_t'(s_op);
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    assign head_prev = (head_reg == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head_reg - 1'b1;
    assign head_succ = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_succ = (tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = STATUS_OK;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        case (op)
            OP_PUSH_TAIL: begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    wr_en      = dp_cmd.exec;
                    wr_addr    = tail_reg;
                    tail_next  = tail_succ;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_PUSH_HEAD: begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    wr_en      = dp_cmd.exec;
                    wr_addr    = head_prev;
                    head_next  = head_prev;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP_HEAD: begin
                if (empty) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    head_next  = head_succ;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                if (empty) begin
                    status_next = STATUS_EMPTY;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= {s_entry_capacity, s_entry_id};
        end
        rd_data_reg <= store_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (dp_cmd.exec) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.exec) begin
            status_reg <= status_next;
        end
    end

    assign count_wide = {{COUNT_W{1'b0}}, count_reg};
    assign dp_status.out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (dp_cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load_out) begin
            out_status_reg        <= status_reg;
            out_head_valid_reg    <= !empty;
            out_head_id_reg       <= empty ? '0 : rd_data_reg[ID_W-1:0];
            out_head_capacity_reg <= empty ? '0 : rd_data_reg[REC_W-1:ID_W];
            out_count_reg         <= count_wide[COUNT_W-1:0];
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_head_valid    = out_head_valid_reg;
    assign m_head_id       = out_head_id_reg;
    assign m_head_capacity = out_head_capacity_reg;
    assign m_entry_count   = out_count_reg;

endmodule

@@ design/queue_with_front_insert.sv @@
// Top level of the bounded double-ended record queue.
//
// Input channel (s_valid/s_ready) carries one request: s_op selects push at
// tail, push at head, pop head or peek; s_entry_id and s_entry_capacity give
// the record for the two push kinds and are ignored otherwise.
// Result channel (m_valid/m_ready) returns one transaction per request: the
// status (ok, full, empty), the head record after the request with its valid
// flag (id and capacity read as zero when the queue is empty) and the count.
// Each result is built in order from the accepting edge, where the pointers
// update and the store is written, through the registered store read at the
// head index, to the load of the result register once that register is free.
// A new request is accepted only after the current one has loaded its result.
// The result register stands apart from the controller: the next request is
// accepted while an earlier result still waits; a stalled receiver holds the
// block in its load step until the waiting result is taken.
// Synchronous active-low reset empties the queue and drops any pending result;
// store contents are not cleared and are read only after being written.
module queue_with_front_insert
    import qwfi_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [ID_W-1:0]     s_entry_id,
    input  logic [CAP_W-1:0]    s_entry_capacity,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_head_valid,
    output logic [ID_W-1:0]     m_head_id,
    output logic [CAP_W-1:0]    m_head_capacity,
    output logic [COUNT_W-1:0]  m_entry_count
);

    qwfi_cmd_t    dp_cmd;
    qwfi_status_t dp_status;

    qwfi_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    qwfi_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .dp_cmd           (dp_cmd),
        .dp_status        (dp_status),
        .s_op             (s_op),
        .s_entry_id       (s_entry_id),
        .s_entry_capacity (s_entry_capacity),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_head_valid     (m_head_valid),
        .m_head_id        (m_head_id),
        .m_head_capacity  (m_head_capacity),
        .m_entry_count    (m_entry_count)
    );

endmodule

@@ design/qwfi_checker.sv @@
// Port-level checks for the record queue, bound to the top level.
module qwfi_checker
    import qwfi_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic                m_head_valid,
    input logic [ID_W-1:0]     m_head_id,
    input logic [CAP_W-1:0]    m_head_capacity,
    input logic [COUNT_W-1:0]  m_entry_count
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_head_id)
            && $stable(m_head_capacity) && $stable(m_entry_count))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_head_valid |-> m_head_id == '0 && m_head_capacity == '0)
        else $error("empty head record not zero");

    a_full_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_FULL |-> m_head_valid)
        else $error("full status without head record");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_EMPTY |-> !m_head_valid && m_entry_count == '0)
        else $error("empty status with records held");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while one is in work");

endmodule

bind queue_with_front_insert qwfi_checker u_qwfi_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for queue_with_front_insert: random and directed requests, checked against a ring-queue predictor.
module tb;
    import qwfi_pkg::*;

    localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
    localparam int RANDOM_REQS = 1300;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AFTER  = 300;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [CAP_W-1:0] cap;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                head_valid;
        logic [ID_W-1:0]     head_id;
        logic [CAP_W-1:0]    head_cap;
        logic [COUNT_W-1:0]  count;
    } reply_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op = OP_PEEK;
    logic [ID_W-1:0]     s_entry_id = '0;
    logic [CAP_W-1:0]    s_entry_capacity = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic                m_head_valid;
    logic [ID_W-1:0]     m_head_id;
    logic [CAP_W-1:0]    m_head_capacity;
    logic [COUNT_W-1:0]  m_entry_count;

    request_t pending_reqs[$];
    reply_t   expected_replies[$];

    logic [31:0] q_store [DEPTH];
    int          q_head;
    int          q_tail;
    int          q_fill;

    int error_count;
    int cycle_count;
    int op_seen [4];
    int full_seen;
    int empty_seen;
    int peak_fill;

    queue_with_front_insert #(
        .QUEUE_DEPTH (DEPTH)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_entry_id       (s_entry_id),
        .s_entry_capacity (s_entry_capacity),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_head_valid     (m_head_valid),
        .m_head_id        (m_head_id),
        .m_head_capacity  (m_head_capacity),
        .m_entry_count    (m_entry_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic reply_t apply_request(op_t op, logic [ID_W-1:0] id,
                                             logic [CAP_W-1:0] cap);
        reply_t      r;
        logic [31:0] rec;
        r = '0;
        r.status = STATUS_OK;
        case (op)
            OP_PUSH_TAIL: begin
                if (q_fill >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    q_store[q_tail] = {cap, id};
                    q_tail = (q_tail + 1) % DEPTH;
                    q_fill++;
                end
            end
            OP_PUSH_HEAD: begin
                if (q_fill >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    q_head = (q_head + DEPTH - 1) % DEPTH;
                    q_store[q_head] = {cap, id};
                    q_fill++;
                end
            end
            OP_POP_HEAD: begin
                if (q_fill == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    q_head = (q_head + 1) % DEPTH;
                    q_fill--;
                end
            end
            default: begin
                if (q_fill == 0) r.status = STATUS_EMPTY;
            end
        endcase
        if (q_fill != 0) begin
            rec = q_store[q_head];
            r.head_valid = 1'b1;
            r.head_id    = rec[15:0];
            r.head_cap   = rec[31:16];
        end
        r.count = q_fill[COUNT_W-1:0];
        return r;
    endfunction

    function automatic bit field_ok(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic add_req(op_t op, logic [ID_W-1:0] id, logic [CAP_W-1:0] cap);
        request_t r;
        r.op  = op;
        r.id  = id;
        r.cap = cap;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [15:0] draw_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // driver
    int  tx_gap;
    bit  tx_burst;
    always @(posedge aclk) begin : drive_requests
        request_t r;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            tx_gap   <= 0;
            tx_burst <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (tx_gap != 0) begin
                s_valid <= 1'b0;
                tx_gap  <= tx_gap - 1;
            end else if (pending_reqs.size() != 0) begin
                r = pending_reqs.pop_front();
                s_op             <= r.op;
                s_entry_id       <= r.id;
                s_entry_capacity <= r.cap;
                s_valid          <= 1'b1;
                tx_gap           <= tx_burst ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 39) == 0) tx_burst <= !tx_burst;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    int rx_wait;
    int rx_hold;
    int rx_taken;
    bit rx_held_once;
    bit rx_burst;
    always @(posedge aclk) begin : drive_ready
        int w;
        if (!aresetn) begin
            m_ready      <= 1'b0;
            rx_wait      <= 0;
            rx_hold      <= 0;
            rx_taken     <= 0;
            rx_held_once <= 1'b0;
            rx_burst     <= 1'b0;
        end else begin
            if (m_valid && m_ready) rx_taken <= rx_taken + 1;
            if (!rx_held_once && rx_taken >= HOLD_AFTER) begin
                rx_held_once <= 1'b1;
                rx_hold      <= HOLD_CYCLES;
                m_ready      <= 1'b0;
            end else if (rx_hold != 0) begin
                rx_hold <= rx_hold - 1;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                w = rx_burst ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 39) == 0) rx_burst <= !rx_burst;
                rx_wait <= w;
                m_ready <= (w == 0);
            end else if (rx_wait != 0) begin
                rx_wait <= rx_wait - 1;
                m_ready <= (rx_wait == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: predict on each accepted request, then check each accepted result
    always @(posedge aclk) begin : watch_channels
        reply_t want;
        bit     ok;
        if (aresetn && s_valid && s_ready) begin
            want = apply_request(op_t'(s_op), s_entry_id, s_entry_capacity);
            expected_replies.push_back(want);
            op_seen[s_op]++;
            if (want.status == STATUS_FULL) full_seen++;
            if (want.status == STATUS_EMPTY) empty_seen++;
            if (q_fill > peak_fill) peak_fill = q_fill;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual status %0d head %0h/%0h count %0d",
                         $time, m_status, m_head_id, m_head_capacity, m_entry_count);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                ok = field_ok("status", want.status, m_status)
                   & field_ok("head_valid", want.head_valid, m_head_valid)
                   & field_ok("head_id", want.head_id, m_head_id)
                   & field_ok("head_capacity", want.head_cap, m_head_capacity)
                   & field_ok("entry_count", want.count, m_entry_count);
                if (!ok) error_count++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d requests and %0d results outstanding",
                     $time, pending_reqs.size(), expected_replies.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int   mode;
        int   seg_left;
        int   pick;
        op_t  op;

        q_head = 0;
        q_tail = 0;
        q_fill = 0;

        add_req(OP_PEEK, 16'hFFFF, 16'hFFFF);
        add_req(OP_POP_HEAD, 16'hFFFF, 16'h0000);
        add_req(OP_PUSH_TAIL, 16'h0000, 16'h0000);
        add_req(OP_PUSH_HEAD, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 14; i++) begin
            add_req(i % 2 ? OP_PUSH_HEAD : OP_PUSH_TAIL, 16'(16'h1000 + i), 16'(16'h8000 | i));
        end
        add_req(OP_PUSH_TAIL, 16'hAAAA, 16'h5555);
        add_req(OP_PUSH_HEAD, 16'h5555, 16'hAAAA);
        add_req(OP_PEEK, 16'h0000, 16'h0000);
        add_req(OP_POP_HEAD, 16'h0000, 16'hFFFF);
        add_req(OP_POP_HEAD, 16'h1234, 16'h4321);

        mode     = 0;
        seg_left = 0;
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(16, 48);
            end
            seg_left--;
            pick = $urandom_range(0, 99);
            case (mode)
                0:       op = pick < 70 ? OP_PUSH_TAIL : (pick < 88 ? OP_POP_HEAD : OP_PEEK);
                1:       op = pick < 70 ? OP_POP_HEAD : (pick < 88 ? OP_PUSH_TAIL : OP_PEEK);
                default: op = pick < 45 ? OP_PUSH_TAIL : (pick < 88 ? OP_POP_HEAD : OP_PEEK);
            endcase
            if (op == OP_PUSH_TAIL && $urandom_range(0, 1)) op = OP_PUSH_HEAD;
            add_req(op, draw_word(), draw_word());
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid || expected_replies.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Ran %0d tail pushes, %0d head pushes, %0d pops, %0d peeks",
                 op_seen[OP_PUSH_TAIL], op_seen[OP_PUSH_HEAD], op_seen[OP_POP_HEAD],
                 op_seen[OP_PEEK]);
        $display("Refused full %0d times, refused empty %0d times, peak depth %0d, %0d mismatches",
                 full_seen, empty_seen, peak_fill, error_count);
        if (error_count == 0 && expected_replies.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ queue_with_front_insert.f @@
design/qwfi_pkg.sv
design/qwfi_ctrl.sv
design/qwfi_datapath.sv
design/queue_with_front_insert.sv
design/qwfi_checker.sv
dv/tb.sv
